// ===== src/max_manhattan_pair_macros.svh =====
// Assertion macros shared by the max_manhattan_pair RTL
`ifndef MAX_MANHATTAN_PAIR_MACROS_SVH
`define MAX_MANHATTAN_PAIR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MMP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mmp assertion failed");

// antecedent implies consequent in the next cycle
`define MMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mmp assertion failed");

`endif

// ===== src/mmp_pkg.sv =====
// Shared types and constants for the max_manhattan_pair block
package mmp_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned SUM_W     = COORD_W + 2;
  localparam int unsigned CAND_W    = SUM_W + 1;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned DIST_W    = 33;
  localparam int unsigned NUM_PAT   = 4;
  localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(65536);
  localparam logic [1:0]       OPP_MASK   = 2'b11;

  typedef struct packed {
    logic [NUM_PAT-1:0][SUM_W-1:0] sum;
    logic [IDX_W-1:0]              idx;
    logic                          keep;
    logic                          last;
    logic                          too_many;
  } mmp_item_t;

endpackage

// ===== src/max_manhattan_pair.sv =====
// A last item passes the queue, stage 1, stage 2 and the result register in turn.
// Throughput: one item per cycle; the pattern-maxima register loop sets that figure.
// A result waiting in the output register stalls the back end; the two-entry
// queue keeps taking items until it fills.
// Reset clears the point counter, overflow flag, pattern fill flags, best-pair
// flag, queue and output valid; the block is ready right after reset.
module max_manhattan_pair import mmp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  input  logic                      skip_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [DIST_W-1:0]         distance_o,
  output logic [IDX_W-1:0]          later_index_o,
  output logic [IDX_W-1:0]          earlier_index_o,
  output logic                      pair_found_o,
  output logic                      too_many_o
);

  logic      push, q_ready, q_valid, pop;
  mmp_item_t f_item, q_item;

  mmp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .x_coord_i  (x_coord_i),
    .y_coord_i  (y_coord_i),
    .skip_i     (skip_i),
    .last_i     (last_i),
    .push_o     (push),
    .item_o     (f_item),
    .q_ready_i  (q_ready)
  );

  mmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  mmp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (q_valid),
    .item_i          (q_item),
    .item_ready_o    (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .distance_o      (distance_o),
    .later_index_o   (later_index_o),
    .earlier_index_o (earlier_index_o),
    .pair_found_o    (pair_found_o),
    .too_many_o      (too_many_o)
  );

endmodule

// ===== src/mmp_front.sv =====
// Front end: point indexing, overflow tracking and sign-pattern sums
`include "max_manhattan_pair_macros.svh"
module mmp_front import mmp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  input  logic                      skip_i,
  input  logic                      last_i,
  output logic                      push_o,
  output mmp_item_t                 item_o,
  input  logic                      q_ready_i
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             at_limit;
  logic             accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign push_o     = accept;
  assign at_limit   = (cnt_q >= MAX_POINTS);

  always_comb begin
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] a;
    logic signed [SUM_W-1:0] b;
    sx = SUM_W'(x_coord_i);
    sy = SUM_W'(y_coord_i);
    for (int j = 0; j < NUM_PAT; j++) begin
      a = (j[0]) ? sx : -sx;
      b = (j[1]) ? sy : -sy;
      item_o.sum[j] = a + b;
    end
    item_o.idx      = cnt_q[IDX_W-1:0];
    item_o.keep     = !skip_i && !at_limit;
    item_o.last     = last_i;
    item_o.too_many = ovf_q || at_limit;
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (last_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (at_limit) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  `MMP_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= MAX_POINTS)
  `MMP_ASSERT_NEXT(a_last_clears, accept && last_i, cnt_q == '0 && !ovf_q)

endmodule

// ===== src/mmp_queue.sv =====
// Two-entry queue between front end and back end
`include "max_manhattan_pair_macros.svh"
module mmp_queue import mmp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mmp_item_t item_i,
  output logic      ready_o,
  output logic      valid_o,
  output mmp_item_t item_o,
  input  logic      pop_i
);

  mmp_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  `MMP_ASSERT_IMPL(a_q_count, 1'b1, cnt_q <= 2'd2)

endmodule

// ===== src/mmp_back.sv =====
// Back end: per-pattern maxima, best-pair search and result register
`include "max_manhattan_pair_macros.svh"
module mmp_back import mmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  mmp_item_t         item_i,
  output logic              item_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DIST_W-1:0] distance_o,
  output logic [IDX_W-1:0]  later_index_o,
  output logic [IDX_W-1:0]  earlier_index_o,
  output logic              pair_found_o,
  output logic              too_many_o
);

  logic en, pop;

  // pattern state
  logic signed [SUM_W-1:0] pb_q [NUM_PAT];
  logic signed [SUM_W-1:0] pb_d [NUM_PAT];
  logic [IDX_W-1:0]        pi_q [NUM_PAT];
  logic [IDX_W-1:0]        pi_d [NUM_PAT];
  logic [NUM_PAT-1:0]      pf_q, pf_d;

  // stage 1: candidates
  logic                     s1_valid_q;
  logic signed [CAND_W-1:0] c_q [NUM_PAT];
  logic signed [CAND_W-1:0] c_d [NUM_PAT];
  logic [IDX_W-1:0]         ce_q [NUM_PAT];
  logic [IDX_W-1:0]         ce_d [NUM_PAT];
  logic [NUM_PAT-1:0]       cv_q, cv_d;
  logic [IDX_W-1:0]         s1_idx_q;
  logic                     s1_last_q, s1_tm_q;

  // stage 2: reduced candidate
  logic                     s2_valid_q;
  logic signed [CAND_W-1:0] m_q, m_d;
  logic [IDX_W-1:0]         me_q, me_d;
  logic                     mv_q, mv_d;
  logic [IDX_W-1:0]         s2_idx_q;
  logic                     s2_last_q, s2_tm_q;

  // best pair
  logic signed [CAND_W-1:0] bd_q, bd_d;
  logic [IDX_W-1:0]         bl_q, bl_d, be_q, be_d;
  logic                     bv_q, bv_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [DIST_W-1:0] out_dist_q;
  logic [IDX_W-1:0]  out_later_q, out_earlier_q;
  logic              out_pair_q, out_tm_q;

  assign en           = !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && en;
  assign item_ready_o = en;

  always_comb begin
    logic [1:0]              opp;
    logic signed [SUM_W-1:0] s;
    pf_d = pf_q;
    for (int j = 0; j < NUM_PAT; j++) begin
      opp     = 2'(j) ^ OPP_MASK;
      s       = $signed(item_i.sum[j]);
      pb_d[j] = pb_q[j];
      pi_d[j] = pi_q[j];
      c_d[j]  = CAND_W'(pb_q[opp]) + CAND_W'(s);
      ce_d[j] = pi_q[opp];
      cv_d[j] = item_i.keep && pf_q[opp];
      if (item_i.keep && (!pf_q[j] || s >= pb_q[j])) begin
        pb_d[j] = s;
        pi_d[j] = item_i.idx;
        pf_d[j] = 1'b1;
      end
    end
    if (item_i.last) begin
      pf_d = '0;
    end
  end

  always_comb begin
    logic signed [CAND_W-1:0] m01, m23;
    logic [IDX_W-1:0]         e01, e23;
    logic                     v01, v23;
    if (cv_q[1] && (!cv_q[0] || c_q[1] > c_q[0])) begin
      m01 = c_q[1];
      e01 = ce_q[1];
    end else begin
      m01 = c_q[0];
      e01 = ce_q[0];
    end
    v01 = cv_q[0] || cv_q[1];
    if (cv_q[3] && (!cv_q[2] || c_q[3] > c_q[2])) begin
      m23 = c_q[3];
      e23 = ce_q[3];
    end else begin
      m23 = c_q[2];
      e23 = ce_q[2];
    end
    v23 = cv_q[2] || cv_q[3];
    if (v23 && (!v01 || m23 > m01)) begin
      m_d  = m23;
      me_d = e23;
    end else begin
      m_d  = m01;
      me_d = e01;
    end
    mv_d = v01 || v23;
  end

  always_comb begin
    bd_d = bd_q;
    bl_d = bl_q;
    be_d = be_q;
    bv_d = bv_q;
    if (mv_q && (!bv_q || m_q > bd_q)) begin
      bd_d = m_q;
      bl_d = s2_idx_q;
      be_d = me_q;
      bv_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (en) begin
      out_valid_d = s2_valid_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf_q        <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      bv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        pf_q <= pf_d;
      end
      if (en) begin
        s1_valid_q <= item_valid_i;
        s2_valid_q <= s1_valid_q;
        if (s2_valid_q) begin
          bv_q <= s2_last_q ? 1'b0 : bv_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      for (int j = 0; j < NUM_PAT; j++) begin
        pb_q[j] <= pb_d[j];
        pi_q[j] <= pi_d[j];
      end
    end
    if (en) begin
      for (int j = 0; j < NUM_PAT; j++) begin
        c_q[j]  <= c_d[j];
        ce_q[j] <= ce_d[j];
      end
      cv_q      <= cv_d;
      s1_idx_q  <= item_i.idx;
      s1_last_q <= item_i.last;
      s1_tm_q   <= item_i.too_many;
      m_q       <= m_d;
      me_q      <= me_d;
      mv_q      <= mv_d;
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;
      s2_tm_q   <= s1_tm_q;
      if (s2_valid_q) begin
        bd_q <= bd_d;
        bl_q <= bl_d;
        be_q <= be_d;
      end
      if (s2_valid_q && s2_last_q) begin
        out_dist_q    <= bv_d ? bd_d[DIST_W-1:0] : '0;
        out_later_q   <= bv_d ? bl_d : '0;
        out_earlier_q <= bv_d ? be_d : '0;
        out_pair_q    <= bv_d;
        out_tm_q      <= s2_tm_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign distance_o      = out_dist_q;
  assign later_index_o   = out_later_q;
  assign earlier_index_o = out_earlier_q;
  assign pair_found_o    = out_pair_q;
  assign too_many_o      = out_tm_q;

  `MMP_ASSERT_NEXT(a_last_empties, pop && item_i.last, pf_q == '0)
  `MMP_ASSERT_IMPL(a_pair_distinct, out_valid_q && out_pair_q, out_later_q != out_earlier_q)

endmodule

// ===== tb/tb_max_manhattan_pair.sv =====
// Self-checking testbench for max_manhattan_pair: random and directed point sets vs. a predictor
`timescale 1ns / 100ps

module tb_max_manhattan_pair;
  import mmp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1590;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_PCT     = 12;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGE} spread_e;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  later_index;
    logic [IDX_W-1:0]  earlier_index;
    logic              pair_found;
    logic              too_many;
  } pair_result_t;

  class manhattan_scoreboard;
    longint       pat_best[NUM_PAT];
    bit           pat_filled[NUM_PAT];
    int unsigned  pat_idx[NUM_PAT];
    longint       best_dist;
    int unsigned  best_later;
    int unsigned  best_earlier;
    bit           best_valid;
    int unsigned  point_count;
    bit           overflowed;
    pair_result_t pending_q[$];
    int unsigned  errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      for (int j = 0; j < NUM_PAT; j++) begin
        pat_best[j]   = 0;
        pat_filled[j] = 1'b0;
        pat_idx[j]    = 0;
      end
      best_dist    = 0;
      best_later   = 0;
      best_earlier = 0;
      best_valid   = 1'b0;
      point_count  = 0;
      overflowed   = 1'b0;
    endfunction

    function longint pattern_sum(int j, longint x, longint y);
      return ((j & 1) ? x : -x) + ((j & 2) ? y : -y);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_point(logic signed [COORD_W-1:0] x_in, logic signed [COORD_W-1:0] y_in,
                             logic is_skip, logic is_last);
      longint       x;
      longint       y;
      longint       cand;
      longint       s;
      int unsigned  idx;
      int           opp;
      pair_result_t res;
      x = longint'(x_in);
      y = longint'(y_in);
      if (point_count >= int'(MAX_POINTS)) begin
        overflowed = 1'b1;
      end else begin
        idx = point_count;
        point_count++;
        if (!is_skip) begin
          for (int j = 0; j < NUM_PAT; j++) begin
            opp = int'(OPP_MASK) ^ j;
            if (pat_filled[opp]) begin
              cand = pat_best[opp] + pattern_sum(j, x, y);
              if (!best_valid || cand > best_dist) begin
                best_dist    = cand;
                best_later   = idx;
                best_earlier = pat_idx[opp];
                best_valid   = 1'b1;
              end
            end
          end
          for (int j = 0; j < NUM_PAT; j++) begin
            s = pattern_sum(j, x, y);
            if (!pat_filled[j] || s >= pat_best[j]) begin
              pat_best[j]   = s;
              pat_idx[j]    = idx;
              pat_filled[j] = 1'b1;
            end
          end
        end
      end
      if (is_last) begin
        res = '0;
        if (best_valid) begin
          res.distance      = DIST_W'(best_dist);
          res.later_index   = IDX_W'(best_later);
          res.earlier_index = IDX_W'(best_earlier);
          res.pair_found    = 1'b1;
        end
        res.too_many = overflowed;
        pending_q.push_back(res);
        clear();
      end
    endfunction

    task check_result(pair_result_t got);
      pair_result_t exp;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result, distance %0d", got.distance));
        return;
      end
      exp = pending_q.pop_front();
      if (got.distance !== exp.distance)
        report($sformatf("distance got %0d exp %0d", got.distance, exp.distance));
      if (got.later_index !== exp.later_index)
        report($sformatf("later_index got %0d exp %0d", got.later_index, exp.later_index));
      if (got.earlier_index !== exp.earlier_index)
        report($sformatf("earlier_index got %0d exp %0d", got.earlier_index,
                         exp.earlier_index));
      if (got.pair_found !== exp.pair_found)
        report($sformatf("pair_found got %0b exp %0b", got.pair_found, exp.pair_found));
      if (got.too_many !== exp.too_many)
        report($sformatf("too_many got %0b exp %0b", got.too_many, exp.too_many));
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] x_coord_i = '0;
  logic signed [COORD_W-1:0] y_coord_i = '0;
  logic                      skip_i = 1'b0;
  logic                      last_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [DIST_W-1:0]         distance_o;
  logic [IDX_W-1:0]          later_index_o;
  logic [IDX_W-1:0]          earlier_index_o;
  logic                      pair_found_o;
  logic                      too_many_o;

  manhattan_scoreboard board = new();
  bit                  src_steady = 1'b0;
  bit                  sink_steady = 1'b0;
  bit                  hold_req = 1'b0;
  int unsigned         cycles = 0;
  int unsigned         items_sent = 0;

  max_manhattan_pair dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .skip_i         (skip_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .distance_o     (distance_o),
    .later_index_o  (later_index_o),
    .earlier_index_o(earlier_index_o),
    .pair_found_o   (pair_found_o),
    .too_many_o     (too_many_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** max_manhattan_pair: FAILED **");
      $finish;
    end
  end

  // Hold off the result channel on request, otherwise stall at random unless the sink is steady.
  initial begin : result_sink
    int unsigned  hold_left;
    pair_result_t got;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= sink_steady || ($urandom_range(99) >= IDLE_PCT);
      end
      @(negedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.distance      = distance_o;
        got.later_index   = later_index_o;
        got.earlier_index = earlier_index_o;
        got.pair_found    = pair_found_o;
        got.too_many      = too_many_o;
        board.check_result(got);
      end
    end
  end

  task automatic send_point(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                            input logic is_skip, input logic is_last);
    bit taken;
    while (!src_steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i  <= x;
    y_coord_i  <= y;
    skip_i     <= is_skip;
    last_i     <= is_last;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      if (!taken) @(posedge clk_i);
    end while (!taken);
    @(posedge clk_i);
    board.note_point(x, y, is_skip, is_last);
    items_sent++;
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(spread_e spread);
    case (spread)
      SPREAD_NARROW: return COORD_W'($urandom_range(8)) - COORD_W'(4);
      SPREAD_EDGE: begin
        if ($urandom_range(1)) return COORD_MAX - COORD_W'($urandom_range(3));
        else return COORD_MIN + COORD_W'($urandom_range(3));
      end
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic send_set(input int unsigned n, input spread_e spread, input int unsigned skip_pct);
    for (int unsigned i = 0; i < n; i++)
      send_point(pick_coord(spread), pick_coord(spread), $urandom_range(99) < skip_pct, i == n - 1);
  endtask

  initial begin : stimulus
    int unsigned n;
    spread_e     spread;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single point, no pair
    send_point(0, 0, 1'b0, 1'b1);
    // every point skipped
    send_point(5, 5, 1'b1, 1'b0);
    send_point(7, 7, 1'b1, 1'b1);
    // largest distance
    send_point(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0, 1'b1);
    send_point(COORD_MIN, COORD_MAX, 1'b0, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0, 1'b1);
    // identical points: ties on both distance and pattern maxima
    send_point(3, 4, 1'b0, 1'b0);
    send_point(3, 4, 1'b0, 1'b0);
    send_point(3, 4, 1'b0, 1'b1);
    // skipped point still takes an index
    send_point(0, 0, 1'b0, 1'b0);
    send_point(100, 100, 1'b1, 1'b0);
    send_point(1, 1, 1'b0, 1'b1);
    // skipped last item
    send_point(0, 0, 1'b0, 1'b0);
    send_point(2, -3, 1'b0, 1'b0);
    send_point(9, 9, 1'b1, 1'b1);
    send_point(-1, -1, 1'b0, 1'b0);
    send_point(1, 1, 1'b0, 1'b0);
    send_point(COORD_MIN, 0, 1'b0, 1'b1);

    // fill the block while results are held off
    hold_req = 1'b1;
    repeat (20) send_set($urandom_range(1, 3), SPREAD_FULL, 10);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      src_steady  = (items_sent > 600 && items_sent < 900);
      sink_steady = src_steady;
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      case ($urandom_range(5)) inside
        0, 1:    spread = SPREAD_NARROW;
        2:       spread = SPREAD_EDGE;
        default: spread = SPREAD_FULL;
      endcase
      send_set(n, spread, ($urandom_range(7) == 0) ? 60 : 15);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    in_valid_i <= 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) $display("** max_manhattan_pair: PASSED **");
    else $display("** max_manhattan_pair: FAILED **");
    $finish;
  end

endmodule
